FILE: hw/rtl/encoder_position_pid_core_defines.svh
// Assertion macros for the encoder position PID core.
// Included by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef ENCODER_POSITION_PID_CORE_DEFINES_SVH
`define ENCODER_POSITION_PID_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/epp_pkg.sv
// Shared widths, codes and constants of the encoder position PID core.
// No dependencies; used by the channel interfaces and the core.
package epp_pkg;

  localparam int WORD_W  = 32;   // ticks, gains, positions, power
  localparam int TIME_W  = 32;   // microsecond timestamps
  localparam int ERR_W   = 33;   // position error
  localparam int INT_W   = 48;   // error integral
  localparam int MC_W    = 54;   // multiplicand, derivative
  localparam int MP_W    = 33;   // multiplier, one bit consumed per step
  localparam int DQ_W    = 54;   // dividend and quotient of the derivative divide
  localparam int ACC_W   = 88;   // shared adder, product and accumulator
  localparam int CNT_W   = 6;
  localparam int STOP_W  = 31;
  localparam int MODE_W  = 2;
  localparam int SHIFT   = 16;   // Q16.16 gains

  localparam int MODE_TUNING_BIT = 0;
  localparam int MODE_DRIVE_BIT  = 1;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MP_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DQ_W - 1);

  localparam logic [MP_W-1:0]   US_PER_SECOND = MP_W'(1000000);
  localparam logic [TIME_W-1:0] PERIOD_RESET  = TIME_W'(10000);

  // Limits on one integral increment: plus and minus two to the 48th.
  localparam logic [ACC_W-1:0] TERM_POS_LIM = {{(ACC_W-INT_W-1){1'b0}}, 1'b1, {INT_W{1'b0}}};
  localparam logic [ACC_W-1:0] TERM_NEG_LIM = {{(ACC_W-INT_W){1'b1}}, {INT_W{1'b0}}};
  localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] POWER_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] POWER_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic {
    OP_START  = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_CONTROL_MODE      = 3'd0,
    REG_GAIN_PROPORTIONAL = 3'd1,
    REG_GAIN_INTEGRAL     = 3'd2,
    REG_GAIN_DERIVATIVE   = 3'd3,
    REG_UPDATE_PERIOD_US  = 3'd4,
    REG_TUNING_SETPOINT   = 3'd5,
    REG_TARGET_DISTANCE   = 3'd6,
    REG_STOP_RANGE        = 3'd7
  } reg_idx_e;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_CHECK  = 14'b00000000000010,
    ST_ERR    = 14'b00000000000100,
    ST_MUL    = 14'b00000000001000,
    ST_CLAMP  = 14'b00000000010000,
    ST_INTADD = 14'b00000000100000,
    ST_DIFF   = 14'b00000001000000,
    ST_ABS    = 14'b00000010000000,
    ST_DIV    = 14'b00000100000000,
    ST_DSIGN  = 14'b00001000000000,
    ST_ACCUM  = 14'b00010000000000,
    ST_POWER  = 14'b00100000000000,
    ST_FLAG   = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_e;

  // Which product the serial multiplier is currently forming.
  typedef enum logic [2:0] {
    JOB_INT = 3'd0,
    JOB_DER = 3'd1,
    JOB_KP  = 3'd2,
    JOB_KI  = 3'd3,
    JOB_KD  = 3'd4
  } job_e;

endpackage

FILE: hw/rtl/epp_in_if.sv
// Input channel of the encoder position PID core: valid, ready and one item.
// Depends on epp_pkg for field widths.
interface epp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic signed [epp_pkg::WORD_W-1:0]  tick_count;
  logic        [epp_pkg::TIME_W-1:0]  now_us;
  logic signed [epp_pkg::WORD_W-1:0]  profile_position;

  modport source (output valid, operation, tick_count, now_us, profile_position, input ready);
  modport sink   (input valid, operation, tick_count, now_us, profile_position, output ready);
endinterface

FILE: hw/rtl/epp_out_if.sv
// Result channel of the encoder position PID core: valid, ready and one item.
// Depends on epp_pkg for field widths.
interface epp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [epp_pkg::WORD_W-1:0]  motor_power;
  logic                               power_updated;
  logic                               keep_running;

  modport source (output valid, motor_power, power_updated, keep_running, input ready);
  modport sink   (input valid, motor_power, power_updated, keep_running, output ready);
endinterface

FILE: hw/rtl/encoder_position_pid_core.sv
// Sequence: a start item goes straight to the flag and done steps; an update checks the period
// first and, when it drives, forms five 33-step serial products and a 54-step restoring divide
// on one shared 88-bit adder before the flag and done steps.
// Flow: one item at a time; the input is ready again once the result is loaded into the output
// register, which may still wait on the sink.
// Reset: asynchronous, active low; sets the sequencer state, loop state and config to defaults.
`include "encoder_position_pid_core_defines.svh"

module encoder_position_pid_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [epp_pkg::WORD_W-1:0]    cfg_data_i,
  epp_in_if.sink                        in_i,
  epp_out_if.source                     out_o
);

  // Configuration registers.
  logic [epp_pkg::MODE_W-1:0] mode_q;
  logic [epp_pkg::WORD_W-1:0] kp_q, ki_q, kd_q;
  logic [epp_pkg::TIME_W-1:0] period_q;
  logic [epp_pkg::WORD_W-1:0] setpoint_q, tdist_q;
  logic [epp_pkg::STOP_W-1:0] stop_q;

  // Loop state.
  logic [epp_pkg::TIME_W-1:0] last_q, last_d;
  logic [epp_pkg::WORD_W-1:0] offset_q, offset_d;
  logic [epp_pkg::WORD_W-1:0] pos_q, pos_d;
  logic [epp_pkg::ERR_W-1:0]  prev_q, prev_d;
  logic [epp_pkg::INT_W-1:0]  integ_q, integ_d;

  // Sequencer.
  epp_pkg::state_e state_q, state_d;
  epp_pkg::job_e   job_q, job_d;
  logic [epp_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // Item and work registers.
  logic [epp_pkg::WORD_W-1:0] tick_q, tick_d;
  logic [epp_pkg::TIME_W-1:0] now_q, now_d;
  logic [epp_pkg::WORD_W-1:0] prof_q, prof_d;
  logic [epp_pkg::TIME_W-1:0] elapsed_q, elapsed_d;
  logic [epp_pkg::ERR_W-1:0]  e_q, e_d;
  logic [epp_pkg::MC_W-1:0]   mcand_q, mcand_d;
  logic [epp_pkg::MP_W-1:0]   mplier_q, mplier_d;
  logic [epp_pkg::ACC_W-1:0]  prod_q, prod_d;
  logic [epp_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [epp_pkg::TIME_W-1:0] rem_q, rem_d;
  logic                       dneg_q, dneg_d;
  logic [epp_pkg::MC_W-1:0]   d_q, d_d;
  logic [epp_pkg::WORD_W-1:0] power_q, power_d;
  logic                       upd_q, upd_d;
  logic                       keep_q, keep_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [epp_pkg::WORD_W-1:0] out_power_q, out_power_d;
  logic                       out_upd_q, out_upd_d;
  logic                       out_keep_q, out_keep_d;

  // Shared adder.
  logic [epp_pkg::ACC_W-1:0] alu_a, alu_b, alu_res;
  logic                      alu_sub;

  logic [epp_pkg::WORD_W-1:0] target;
  logic                       qbit;
  logic                       int_fits, acc_fits;
  logic [epp_pkg::ERR_W-1:0]  gap;
  logic [epp_pkg::ERR_W-1:0]  stop_ext;

  assign alu_res = alu_a + (alu_b ^ {epp_pkg::ACC_W{alu_sub}})
                 + {{(epp_pkg::ACC_W-1){1'b0}}, alu_sub};

  assign target = mode_q[epp_pkg::MODE_TUNING_BIT] ? setpoint_q : prof_q;
  assign qbit   = ~alu_res[epp_pkg::ACC_W-1];

  // A value fits a narrower signed field when all bits above its sign agree.
  assign int_fits = (&alu_res[epp_pkg::ACC_W-1:epp_pkg::INT_W-1])
                  | ~(|alu_res[epp_pkg::ACC_W-1:epp_pkg::INT_W-1]);
  assign acc_fits = (&acc_q[epp_pkg::ACC_W-1:epp_pkg::WORD_W+epp_pkg::SHIFT-1])
                  | ~(|acc_q[epp_pkg::ACC_W-1:epp_pkg::WORD_W+epp_pkg::SHIFT-1]);

  assign gap      = alu_res[epp_pkg::ERR_W-1:0];
  assign stop_ext = {{(epp_pkg::ERR_W-epp_pkg::STOP_W){1'b0}}, stop_q};

  assign in_i.ready          = (state_q == epp_pkg::ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.motor_power   = out_power_q;
  assign out_o.power_updated = out_upd_q;
  assign out_o.keep_running  = out_keep_q;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      epp_pkg::ST_IDLE: begin
        alu_a   = {{(epp_pkg::ACC_W-epp_pkg::TIME_W){1'b0}}, in_i.now_us};
        alu_b   = {{(epp_pkg::ACC_W-epp_pkg::TIME_W){1'b0}}, last_q};
        alu_sub = 1'b1;
      end
      epp_pkg::ST_CHECK: begin
        alu_a   = {{(epp_pkg::ACC_W-epp_pkg::WORD_W){1'b0}}, tick_q};
        alu_b   = {{(epp_pkg::ACC_W-epp_pkg::WORD_W){1'b0}}, offset_q};
        alu_sub = 1'b1;
      end
      epp_pkg::ST_ERR: begin
        alu_a   = {{(epp_pkg::ACC_W-epp_pkg::WORD_W){target[epp_pkg::WORD_W-1]}}, target};
        alu_b   = {{(epp_pkg::ACC_W-epp_pkg::WORD_W){pos_q[epp_pkg::WORD_W-1]}}, pos_q};
        alu_sub = 1'b1;
      end
      epp_pkg::ST_MUL: begin
        // MSB first; the top multiplier bit carries negative weight.
        alu_a   = {prod_q[epp_pkg::ACC_W-2:0], 1'b0};
        alu_b   = mplier_q[epp_pkg::MP_W-1]
                ? {{(epp_pkg::ACC_W-epp_pkg::MC_W){mcand_q[epp_pkg::MC_W-1]}}, mcand_q}
                : '0;
        alu_sub = (cnt_q == '0);
      end
      epp_pkg::ST_INTADD: begin
        alu_a = {{(epp_pkg::ACC_W-epp_pkg::INT_W){integ_q[epp_pkg::INT_W-1]}}, integ_q};
        alu_b = prod_q;
      end
      epp_pkg::ST_DIFF: begin
        alu_a   = {{(epp_pkg::ACC_W-epp_pkg::ERR_W){e_q[epp_pkg::ERR_W-1]}}, e_q};
        alu_b   = {{(epp_pkg::ACC_W-epp_pkg::ERR_W){prev_q[epp_pkg::ERR_W-1]}}, prev_q};
        alu_sub = 1'b1;
      end
      epp_pkg::ST_ABS: begin
        alu_b   = prod_q;
        alu_sub = prod_q[epp_pkg::ACC_W-1];
      end
      epp_pkg::ST_DIV: begin
        alu_a   = {{(epp_pkg::ACC_W-epp_pkg::TIME_W-1){1'b0}}, rem_q,
                   prod_q[epp_pkg::DQ_W-1]};
        alu_b   = {{(epp_pkg::ACC_W-epp_pkg::TIME_W){1'b0}}, elapsed_q};
        alu_sub = 1'b1;
      end
      epp_pkg::ST_DSIGN: begin
        alu_b   = {{(epp_pkg::ACC_W-epp_pkg::DQ_W){1'b0}}, prod_q[epp_pkg::DQ_W-1:0]};
        alu_sub = dneg_q;
      end
      epp_pkg::ST_ACCUM: begin
        alu_a = acc_q;
        alu_b = prod_q;
      end
      epp_pkg::ST_FLAG: begin
        alu_a   = {{(epp_pkg::ACC_W-epp_pkg::WORD_W){pos_q[epp_pkg::WORD_W-1]}}, pos_q};
        alu_b   = {{(epp_pkg::ACC_W-epp_pkg::WORD_W){tdist_q[epp_pkg::WORD_W-1]}}, tdist_q};
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    offset_d    = offset_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    integ_d     = integ_q;
    tick_d      = tick_q;
    now_d       = now_q;
    prof_d      = prof_q;
    elapsed_d   = elapsed_q;
    e_d         = e_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    dneg_d      = dneg_q;
    d_d         = d_q;
    power_d     = power_q;
    upd_d       = upd_q;
    keep_d      = keep_q;
    out_valid_d = out_valid_q;
    out_power_d = out_power_q;
    out_upd_d   = out_upd_q;
    out_keep_d  = out_keep_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      epp_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          tick_d    = in_i.tick_count;
          now_d     = in_i.now_us;
          prof_d    = in_i.profile_position;
          elapsed_d = alu_res[epp_pkg::TIME_W-1:0];
          power_d   = '0;
          upd_d     = 1'b0;
          if (epp_pkg::op_e'(in_i.operation) == epp_pkg::OP_START) begin
            offset_d = in_i.tick_count;
            last_d   = in_i.now_us;
            pos_d    = '0;
            prev_d   = '0;
            integ_d  = '0;
            state_d  = epp_pkg::ST_FLAG;
          end else begin
            state_d = epp_pkg::ST_CHECK;
          end
        end
      end
      epp_pkg::ST_CHECK: begin
        if (elapsed_q > period_q) begin
          pos_d   = alu_res[epp_pkg::WORD_W-1:0];
          last_d  = now_q;
          state_d = mode_q[epp_pkg::MODE_DRIVE_BIT] ? epp_pkg::ST_ERR : epp_pkg::ST_FLAG;
        end else begin
          state_d = epp_pkg::ST_FLAG;
        end
      end
      epp_pkg::ST_ERR: begin
        // Integral increment first: error times elapsed time.
        e_d      = alu_res[epp_pkg::ERR_W-1:0];
        mplier_d = alu_res[epp_pkg::MP_W-1:0];
        mcand_d  = {{(epp_pkg::MC_W-epp_pkg::TIME_W){1'b0}}, elapsed_q};
        prod_d   = '0;
        cnt_d    = '0;
        job_d    = epp_pkg::JOB_INT;
        state_d  = epp_pkg::ST_MUL;
      end
      epp_pkg::ST_MUL: begin
        prod_d   = alu_res;
        mplier_d = {mplier_q[epp_pkg::MP_W-2:0], 1'b0};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == epp_pkg::MUL_LAST) begin
          cnt_d = '0;
          unique case (job_q)
            epp_pkg::JOB_INT: state_d = epp_pkg::ST_CLAMP;
            epp_pkg::JOB_DER: state_d = epp_pkg::ST_ABS;
            default:          state_d = epp_pkg::ST_ACCUM;
          endcase
        end
      end
      epp_pkg::ST_CLAMP: begin
        if (!prod_q[epp_pkg::ACC_W-1] && (|prod_q[epp_pkg::ACC_W-1:epp_pkg::INT_W])) begin
          prod_d = epp_pkg::TERM_POS_LIM;
        end else if (prod_q[epp_pkg::ACC_W-1] &&
                     !(&prod_q[epp_pkg::ACC_W-1:epp_pkg::INT_W])) begin
          prod_d = epp_pkg::TERM_NEG_LIM;
        end
        state_d = epp_pkg::ST_INTADD;
      end
      epp_pkg::ST_INTADD: begin
        if (int_fits) begin
          integ_d = alu_res[epp_pkg::INT_W-1:0];
        end else begin
          integ_d = alu_res[epp_pkg::ACC_W-1] ? epp_pkg::INT_MIN : epp_pkg::INT_MAX;
        end
        state_d = epp_pkg::ST_DIFF;
      end
      epp_pkg::ST_DIFF: begin
        mcand_d  = alu_res[epp_pkg::MC_W-1:0];
        mplier_d = epp_pkg::US_PER_SECOND;
        prod_d   = '0;
        cnt_d    = '0;
        job_d    = epp_pkg::JOB_DER;
        state_d  = epp_pkg::ST_MUL;
      end
      epp_pkg::ST_ABS: begin
        // Divide the magnitude; the sign goes back on afterwards, truncating toward zero.
        prod_d  = alu_res;
        dneg_d  = prod_q[epp_pkg::ACC_W-1];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = epp_pkg::ST_DIV;
      end
      epp_pkg::ST_DIV: begin
        prod_d = {{(epp_pkg::ACC_W-epp_pkg::DQ_W){1'b0}}, prod_q[epp_pkg::DQ_W-2:0], qbit};
        rem_d  = qbit ? alu_res[epp_pkg::TIME_W-1:0]
                      : {rem_q[epp_pkg::TIME_W-2:0], prod_q[epp_pkg::DQ_W-1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == epp_pkg::DIV_LAST) begin
          cnt_d   = '0;
          state_d = epp_pkg::ST_DSIGN;
        end
      end
      epp_pkg::ST_DSIGN: begin
        d_d      = alu_res[epp_pkg::MC_W-1:0];
        mcand_d  = {{(epp_pkg::MC_W-epp_pkg::ERR_W){e_q[epp_pkg::ERR_W-1]}}, e_q};
        mplier_d = {kp_q[epp_pkg::WORD_W-1], kp_q};
        prod_d   = '0;
        acc_d    = '0;
        cnt_d    = '0;
        job_d    = epp_pkg::JOB_KP;
        state_d  = epp_pkg::ST_MUL;
      end
      epp_pkg::ST_ACCUM: begin
        acc_d  = alu_res;
        prod_d = '0;
        cnt_d  = '0;
        unique case (job_q)
          epp_pkg::JOB_KP: begin
            mcand_d  = {{(epp_pkg::MC_W-epp_pkg::INT_W){integ_q[epp_pkg::INT_W-1]}}, integ_q};
            mplier_d = {ki_q[epp_pkg::WORD_W-1], ki_q};
            job_d    = epp_pkg::JOB_KI;
            state_d  = epp_pkg::ST_MUL;
          end
          epp_pkg::JOB_KI: begin
            mcand_d  = d_q;
            mplier_d = {kd_q[epp_pkg::WORD_W-1], kd_q};
            job_d    = epp_pkg::JOB_KD;
            state_d  = epp_pkg::ST_MUL;
          end
          default: state_d = epp_pkg::ST_POWER;
        endcase
      end
      epp_pkg::ST_POWER: begin
        if (acc_fits) begin
          power_d = acc_q[epp_pkg::WORD_W+epp_pkg::SHIFT-1:epp_pkg::SHIFT];
        end else begin
          power_d = acc_q[epp_pkg::ACC_W-1] ? epp_pkg::POWER_MIN : epp_pkg::POWER_MAX;
        end
        upd_d   = 1'b1;
        prev_d  = e_q;
        state_d = epp_pkg::ST_FLAG;
      end
      epp_pkg::ST_FLAG: begin
        // For a negative gap, its inverse is the magnitude minus one.
        keep_d  = mode_q[epp_pkg::MODE_TUNING_BIT]
                | (gap[epp_pkg::ERR_W-1] ? (~gap >= stop_ext) : (gap > stop_ext));
        state_d = epp_pkg::ST_DONE;
      end
      epp_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_power_d = power_q;
          out_upd_d   = upd_q;
          out_keep_d  = keep_q;
          state_d     = epp_pkg::ST_IDLE;
        end
      end
      default: state_d = epp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= epp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      offset_q    <= '0;
      pos_q       <= '0;
      prev_q      <= '0;
      integ_q     <= '0;
      mode_q      <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      period_q    <= epp_pkg::PERIOD_RESET;
      setpoint_q  <= '0;
      tdist_q     <= '0;
      stop_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      offset_q    <= offset_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      if (cfg_we_i) begin
        unique case (epp_pkg::reg_idx_e'(cfg_idx_i))
          epp_pkg::REG_CONTROL_MODE:      mode_q     <= cfg_data_i[epp_pkg::MODE_W-1:0];
          epp_pkg::REG_GAIN_PROPORTIONAL: kp_q       <= cfg_data_i;
          epp_pkg::REG_GAIN_INTEGRAL:     ki_q       <= cfg_data_i;
          epp_pkg::REG_GAIN_DERIVATIVE:   kd_q       <= cfg_data_i;
          epp_pkg::REG_UPDATE_PERIOD_US:  period_q   <= cfg_data_i;
          epp_pkg::REG_TUNING_SETPOINT:   setpoint_q <= cfg_data_i;
          epp_pkg::REG_TARGET_DISTANCE:   tdist_q    <= cfg_data_i;
          epp_pkg::REG_STOP_RANGE:        stop_q     <= cfg_data_i[epp_pkg::STOP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    cnt_q       <= cnt_d;
    tick_q      <= tick_d;
    now_q       <= now_d;
    prof_q      <= prof_d;
    elapsed_q   <= elapsed_d;
    e_q         <= e_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    dneg_q      <= dneg_d;
    d_q         <= d_d;
    power_q     <= power_d;
    upd_q       <= upd_d;
    keep_q      <= keep_d;
    out_power_q <= out_power_d;
    out_upd_q   <= out_upd_d;
    out_keep_q  <= out_keep_d;
  end

  `EPP_ASSERT_NEXT(a_accept_starts_work, in_i.valid && in_i.ready, state_q != epp_pkg::ST_IDLE, "accepted item did not start work")
  `EPP_ASSERT_NOW(a_result_from_done, $rose(out_valid_q), $past(state_q == epp_pkg::ST_DONE), "result appeared outside the done step")
  `EPP_ASSERT_NOW(a_no_update_no_power, out_valid_q && !out_upd_q, out_power_q == '0, "drive value without an update")
  `EPP_ASSERT_NOW(a_div_rem_below, state_q == epp_pkg::ST_DIV, rem_q < elapsed_q, "divider remainder not below divisor")

endmodule

FILE: tb/encoder_position_pid_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for encoder_position_pid_core: directed and random items
// with random idling on both channels. Depends on epp_pkg, epp_in_if and epp_out_if.
module encoder_position_pid_core_tb;

  localparam longint US_PER_S = 1_000_000;
  localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam logic signed [95:0] PWR_HI = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] PWR_LO = -96'sh8000_0000;

  typedef struct {
    epp_pkg::op_e       op;
    logic signed [31:0] ticks;
    logic [31:0]        now;
    logic signed [31:0] profile;
  } loop_item_t;

  typedef struct {
    logic signed [31:0] power;
    logic               updated;
    logic               running;
  } drive_result_t;

  // Mirrors the control loop and keeps the drive results still owed by the block.
  class pid_loop_checker;
    logic [1:0]         mode;
    logic signed [31:0] kp, ki, kd, setpoint, target_dist;
    logic [31:0]        period;
    logic [30:0]        stop_band;
    logic [31:0]        last_update, offset_ticks;
    logic signed [31:0] position;
    logic signed [32:0] prev_error;
    logic signed [47:0] err_integral;
    drive_result_t      drive_due[$];
    int                 mismatches;

    function new();
      mode = '0;
      kp = '0;
      ki = '0;
      kd = '0;
      period = epp_pkg::PERIOD_RESET;
      setpoint = '0;
      target_dist = '0;
      stop_band = '0;
      last_update = '0;
      offset_ticks = '0;
      position = '0;
      prev_error = '0;
      err_integral = '0;
      mismatches = 0;
    endfunction

    function void write_reg(epp_pkg::reg_idx_e idx, logic [31:0] data);
      case (idx)
        epp_pkg::REG_CONTROL_MODE:      mode = data[1:0];
        epp_pkg::REG_GAIN_PROPORTIONAL: kp = data;
        epp_pkg::REG_GAIN_INTEGRAL:     ki = data;
        epp_pkg::REG_GAIN_DERIVATIVE:   kd = data;
        epp_pkg::REG_UPDATE_PERIOD_US:  period = data;
        epp_pkg::REG_TUNING_SETPOINT:   setpoint = data;
        epp_pkg::REG_TARGET_DISTANCE:   target_dist = data;
        epp_pkg::REG_STOP_RANGE:        stop_band = data[30:0];
        default: ;
      endcase
    endfunction

    function void note_item(loop_item_t it);
      logic [31:0]        elapsed;
      longint             target, err, deriv, abs_err, step, acc_int, diff;
      logic [65:0]        mag;
      logic signed [95:0] w_kp, w_ki, w_kd, w_err, w_int, w_der, acc;
      drive_result_t      r;
      r.power = '0;
      r.updated = 1'b0;
      if (it.op == epp_pkg::OP_START) begin
        offset_ticks = it.ticks;
        last_update = it.now;
        position = '0;
        prev_error = '0;
        err_integral = '0;
      end else begin
        elapsed = it.now - last_update;
        if (elapsed > period) begin
          position = it.ticks - offset_ticks;
          if (mode[epp_pkg::MODE_DRIVE_BIT]) begin
            target = mode[epp_pkg::MODE_TUNING_BIT] ? longint'(setpoint)
                                                    : longint'(it.profile);
            err = target - longint'(position);
            deriv = (err - longint'(prev_error)) * US_PER_S / longint'(elapsed);
            abs_err = (err < 0) ? -err : err;
            // One integral increment is limited to two to the 48th before the add.
            mag = 66'(abs_err) * 66'(elapsed);
            if (mag > 66'h1_0000_0000_0000) mag = 66'h1_0000_0000_0000;
            step = longint'(mag[48:0]);
            if (err < 0) step = -step;
            acc_int = longint'(err_integral) + step;
            if (acc_int > INTEG_HI) acc_int = INTEG_HI;
            if (acc_int < INTEG_LO) acc_int = INTEG_LO;
            err_integral = acc_int[47:0];
            w_kp = kp;
            w_ki = ki;
            w_kd = kd;
            w_err = err;
            w_int = err_integral;
            w_der = deriv;
            acc = (w_kp * w_err + w_ki * w_int + w_kd * w_der) >>> epp_pkg::SHIFT;
            if (acc > PWR_HI) r.power = epp_pkg::POWER_MAX;
            else if (acc < PWR_LO) r.power = epp_pkg::POWER_MIN;
            else r.power = acc[31:0];
            r.updated = 1'b1;
            prev_error = err[32:0];
          end
          last_update = it.now;
        end
      end
      if (mode[epp_pkg::MODE_TUNING_BIT]) begin
        r.running = 1'b1;
      end else begin
        diff = longint'(position) - longint'(target_dist);
        if (diff < 0) diff = -diff;
        r.running = diff > longint'(stop_band);
      end
      drive_due.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch: %s", what);
    endtask

    task check_result(drive_result_t got);
      drive_result_t exp_r;
      if (drive_due.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        exp_r = drive_due.pop_front();
        if (got.power !== exp_r.power)
          report_mismatch($sformatf("motor_power %0d, predicted %0d", got.power, exp_r.power));
        if (got.updated !== exp_r.updated)
          report_mismatch($sformatf("power_updated %b, predicted %b", got.updated,
                                    exp_r.updated));
        if (got.running !== exp_r.running)
          report_mismatch($sformatf("keep_running %b, predicted %b", got.running,
                                    exp_r.running));
      end
    endtask

    task check_empty();
      if (drive_due.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", drive_due.size()));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  epp_in_if  in_ch ();
  epp_out_if out_ch ();

  encoder_position_pid_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  pid_loop_checker sb;
  bit              hold_req;
  int              tx_burst;
  int              rx_burst;
  loop_item_t      seen_item;
  drive_result_t   seen_res;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_item.op = epp_pkg::op_e'(in_ch.operation);
        seen_item.ticks = in_ch.tick_count;
        seen_item.now = in_ch.now_us;
        seen_item.profile = in_ch.profile_position;
        sb.note_item(seen_item);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_res.power = out_ch.motor_power;
        seen_res.updated = out_ch.power_updated;
        seen_res.running = out_ch.keep_running;
        sb.check_result(seen_res);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(epp_pkg::op_e op, logic [31:0] ticks, logic [31:0] now_v,
                           logic [31:0] prof);
    int gap;
    if (tx_burst > 0) begin
      tx_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) tx_burst = 25;
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.tick_count <= ticks;
    in_ch.now_us <= now_v;
    in_ch.profile_position <= prof;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Keeps the write enable high; the caller lowers it after the last write.
  task automatic write_cfg(epp_pkg::reg_idx_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.drive_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word(int unsigned span);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return $urandom();
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  task automatic run_phase(int n_items, int hold_at);
    logic [31:0]  word, spread, delta, ticks, prof, offs;
    epp_pkg::op_e op;
    int           kind;
    word = $urandom();
    word[epp_pkg::MODE_DRIVE_BIT] = ($urandom_range(0, 4) != 0);
    write_cfg(epp_pkg::REG_CONTROL_MODE, word);
    write_cfg(epp_pkg::REG_GAIN_PROPORTIONAL, pick_word(1 << 18));
    write_cfg(epp_pkg::REG_GAIN_INTEGRAL, pick_word(1 << 12));
    write_cfg(epp_pkg::REG_GAIN_DERIVATIVE, pick_word(1 << 14));
    case ($urandom_range(0, 9))
      0: word = '0;
      1: word = 32'hFFFF_FFFF;
      2: word = epp_pkg::PERIOD_RESET;
      3: word = $urandom();
      4: word = $urandom_range(0, 200000);
      default: word = $urandom_range(0, 2000);
    endcase
    write_cfg(epp_pkg::REG_UPDATE_PERIOD_US, word);
    write_cfg(epp_pkg::REG_TUNING_SETPOINT, pick_word(5000));
    write_cfg(epp_pkg::REG_TARGET_DISTANCE, pick_word(5000));
    word = $urandom();
    if ($urandom_range(0, 1) == 1) word[30:0] = 31'($urandom_range(0, 3000));
    write_cfg(epp_pkg::REG_STOP_RANGE, word);
    cfg_we_i <= 1'b0;
    spread = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 32'h7FFF_FFFF)
                                         : $urandom_range(1, 5000);
    for (int k = 0; k < n_items; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      // Default is a well-formed update: just past the period, near the last position.
      op = epp_pkg::OP_UPDATE;
      ticks = sb.offset_ticks + sb.position + ($urandom_range(0, 600) - 300);
      prof = sb.position + ($urandom_range(0, 4000) - 2000);
      delta = sb.period + 1 + $urandom_range(0, spread);
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        op = epp_pkg::OP_START;
        ticks = $urandom();
        delta = $urandom_range(0, spread);
      end else if (kind < 12) begin
        op = epp_pkg::op_e'($urandom_range(0, 1));
        ticks = $urandom();
        prof = $urandom();
        delta = $urandom();
      end else begin
        case ($urandom_range(0, 9))
          0: delta = $urandom_range(0, sb.period);
          1: delta = sb.period;
          2: delta = sb.period + 1;
          default: ;
        endcase
        case ($urandom_range(0, 9))
          0: ticks = $urandom();
          1, 2: begin
            // Land on the edge of the stop range so the running flag toggles.
            offs = sb.stop_band + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1) == 1) offs = -offs;
            ticks = sb.offset_ticks + sb.target_dist + offs;
          end
          default: ;
        endcase
        case ($urandom_range(0, 9))
          0: prof = $urandom();
          1: prof = 32'h7FFF_FFFF;
          2: prof = 32'h8000_0000;
          default: ;
        endcase
      end
      send_item(op, ticks, sb.last_update + delta, prof);
    end
    drain();
  endtask

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 400;
      end else if (rx_burst > 0) begin
        rx_burst--;
        stall = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_burst = 25;
        stall = $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = epp_pkg::REG_CONTROL_MODE;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = epp_pkg::OP_START;
    in_ch.tick_count = '0;
    in_ch.now_us = '0;
    in_ch.profile_position = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    tx_burst = 0;
    rx_burst = 0;
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: period boundary across a timer wrap, drive disabled.
    send_item(epp_pkg::OP_START, 32'h7FFF_FFFF, 32'hFFFF_F000, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h8000_0000, 32'hFFFF_F000 + 32'd10000, 32'h7FFF_FFFF);
    send_item(epp_pkg::OP_UPDATE, 32'h8000_0000, 32'hFFFF_F000 + 32'd10001, 32'h8000_0000);
    send_item(epp_pkg::OP_UPDATE, 32'h0, 32'hFFFF_F000 + 32'd10002, 32'hFFFF_FFFF);
    drain();

    // Tuning with extreme gains and zero period: largest errors, integral saturation.
    write_cfg(epp_pkg::REG_CONTROL_MODE, 32'hFFFF_FFFF);
    write_cfg(epp_pkg::REG_GAIN_PROPORTIONAL, 32'h7FFF_FFFF);
    write_cfg(epp_pkg::REG_GAIN_INTEGRAL, 32'h8000_0000);
    write_cfg(epp_pkg::REG_GAIN_DERIVATIVE, 32'h7FFF_FFFF);
    write_cfg(epp_pkg::REG_UPDATE_PERIOD_US, 32'h0);
    write_cfg(epp_pkg::REG_TUNING_SETPOINT, 32'h7FFF_FFFF);
    write_cfg(epp_pkg::REG_TARGET_DISTANCE, 32'h8000_0000);
    write_cfg(epp_pkg::REG_STOP_RANGE, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;
    send_item(epp_pkg::OP_START, 32'h8000_0000, 32'h0, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h8000_0000, 32'h0, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'h1, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h0, 32'h8000_0000, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    // Track run with the largest period: the full timer span never exceeds it.
    write_cfg(epp_pkg::REG_CONTROL_MODE, 32'h2);
    write_cfg(epp_pkg::REG_GAIN_PROPORTIONAL, 32'h8000_0000);
    write_cfg(epp_pkg::REG_GAIN_INTEGRAL, 32'h7FFF_FFFF);
    write_cfg(epp_pkg::REG_GAIN_DERIVATIVE, 32'h8000_0000);
    write_cfg(epp_pkg::REG_UPDATE_PERIOD_US, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;
    send_item(epp_pkg::OP_START, 32'h1234_5678, 32'h10, 32'h0);
    send_item(epp_pkg::OP_UPDATE, 32'h0, 32'hF, 32'h7FFF_FFFF);
    drain();

    // Period of one, zero stop range, profile extremes.
    write_cfg(epp_pkg::REG_UPDATE_PERIOD_US, 32'h1);
    write_cfg(epp_pkg::REG_TARGET_DISTANCE, 32'h7FFF_FFFF);
    write_cfg(epp_pkg::REG_STOP_RANGE, 32'h0);
    cfg_we_i <= 1'b0;
    send_item(epp_pkg::OP_UPDATE, 32'h0, 32'h10, 32'h7FFF_FFFF);
    send_item(epp_pkg::OP_UPDATE, 32'h8000_0000, 32'h11, 32'h7FFF_FFFF);
    send_item(epp_pkg::OP_UPDATE, 32'h8000_0000, 32'h12, 32'h8000_0000);
    send_item(epp_pkg::OP_UPDATE, 32'h1234_5678 + 32'h7FFF_FFFF, 32'h20, 32'h7FFF_FFFF);
    send_item(epp_pkg::OP_UPDATE, 32'h1234_5678 + 32'h7FFF_FFFE, 32'h30, 32'h8000_0000);
    drain();

    for (int ph = 0; ph < 12; ph++) run_phase(112, (ph == 2 || ph == 7) ? 40 : -1);

    repeat (250) @(posedge clk_i);
    sb.check_empty();
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
